// ===== sv/adpcmb_pkg.sv =====
package adpcmb_pkg;

	localparam int MEM_BYTES_DEF = 65536;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NIB_W = 25;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [2:0] REG_START = 3'd0;
	localparam logic [2:0] REG_END   = 3'd1;
	localparam logic [2:0] REG_SHIFT = 3'd2;
	localparam logic [2:0] REG_PSTEP = 3'd3;
	localparam logic [2:0] REG_VOL   = 3'd4;

	localparam logic [14:0] STEP_MIN = 15'd127;
	localparam logic [14:0] STEP_MAX = 15'd24576;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] mem_address;
		logic [7:0]  mem_byte;
		logic        repeat_flag;
		logic        external_mode;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               end_of_sample;
		logic               playing;
	} out_item_t;

	function automatic logic [7:0] grow_factor(input logic [2:0] m);
		case (m)
			3'd4:    grow_factor = 8'd77;
			3'd5:    grow_factor = 8'd102;
			3'd6:    grow_factor = 8'd128;
			3'd7:    grow_factor = 8'd153;
			default: grow_factor = 8'd57;
		endcase
	endfunction

endpackage

// ===== sv/adpcm_b_sample_player.sv =====
// Path, input to result transaction: load, start, stop and non-playing ticks go
// straight to the output state; a playing tick reads RAM for each high nibble and
// uses the held byte for each low nibble; an end without repeat cuts it short.
// Throughput: one transaction at a time through the decode engine; a 2-entry
// input queue decouples acceptance.
// Reset: arst_n clears all control, predictor and registers; RAM is not cleared.
module adpcm_b_sample_player #(
	parameter int MEM_BYTES = adpcmb_pkg::MEM_BYTES_DEF,
	parameter int FRAC_BITS = adpcmb_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  adpcmb_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output adpcmb_pkg::out_item_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [17:0]           cfg_data
);
	import adpcmb_pkg::*;

	logic [15:0] start_q, end_q, vol_q;
	logic [3:0]  shift_q;
	logic [17:0] pstep_q;
	logic        q_valid, q_ready, busy;
	in_item_t    q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0; end_q <= '0; shift_q <= '0; pstep_q <= '0; vol_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START: start_q <= cfg_data[15:0];
				REG_END:   end_q   <= cfg_data[15:0];
				REG_SHIFT: shift_q <= cfg_data[3:0];
				REG_PSTEP: pstep_q <= cfg_data;
				REG_VOL:   vol_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	adpcmb_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	adpcmb_back #(.MEM_BYTES(MEM_BYTES), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_data(q_data), .start_page(start_q), .end_page(end_q),
		.address_shift(shift_q), .phase_step(pstep_q), .volume_gain(vol_q),
		.busy(busy), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

`ifndef ASSERT_OFF
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |=> busy) else $error("engine did not start");
	a_play_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.playing && out_data.end_of_sample))
		else $error("playing with end flag");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule

// ===== sv/adpcmb_ram.sv =====
module adpcmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/adpcmb_front.sv =====
module adpcmb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  adpcmb_pkg::in_item_t in_data,
	output logic                 q_valid,
	input  logic                 q_ready,
	output adpcmb_pkg::in_item_t q_data
);
	import adpcmb_pkg::*;

	localparam int DEPTH = 2;

	in_item_t    buf_q [DEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign in_ready = (cnt_q != 2'(DEPTH));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = buf_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ===== sv/adpcmb_back.sv =====
module adpcmb_back #(
	parameter int MEM_BYTES = adpcmb_pkg::MEM_BYTES_DEF,
	parameter int FRAC_BITS = adpcmb_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  adpcmb_pkg::in_item_t  q_data,
	input  logic [15:0]           start_page,
	input  logic [15:0]           end_page,
	input  logic [3:0]            address_shift,
	input  logic [17:0]           phase_step,
	input  logic [15:0]           volume_gain,
	output logic                  busy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output adpcmb_pkg::out_item_t out_data
);
	import adpcmb_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int WH = 19 - FRAC_BITS > 1 ? 19 - FRAC_BITS : 1;
	localparam int TW = (FRAC_BITS > 18 ? FRAC_BITS : 18) + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_RDWT  = 4'd2;
	localparam logic [3:0] S_RD    = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_UPD   = 4'd5;
	localparam logic [3:0] S_INT   = 4'd6;
	localparam logic [3:0] S_VOL   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0]           st_q;
	in_item_t             it_q;
	logic [NIB_W-1:0]     nib_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic signed [15:0]   acc_q, prev_q;
	logic [14:0]          step_q;
	logic [7:0]           byte_q;
	logic                 play_q, rpt_q, ext_q, eos_q;
	logic [WH-1:0]        whole_q;
	logic [3:0]           nib_val_q;
	logic signed [20:0]   dlt_q;
	logic [22:0]          grow_q;
	logic signed [16+FRAC_BITS+1:0] s_q;
	logic signed [31:0]   smp_q;
	logic                 ovalid_q;
	out_item_t            odata_q;

	logic [3:0]  sh;
	logic [24:0] sbyte, ebyte_raw, ebyte;
	logic [7:0]  rdata;
	logic [TW-1:0] total;
	logic signed [17:0] acc_sum;
	logic [16:0] grow_div;
	logic [16+FRAC_BITS+1:0] s_mag;
	logic signed [16:0] q_int;

	assign sh        = address_shift > 4'd8 ? 4'd8 : address_shift;
	assign sbyte     = 25'(start_page) << sh;
	assign ebyte_raw = (25'(end_page) << sh) + ((25'd1 << sh) - 25'd1);
	assign ebyte     = ebyte_raw >= 25'(MEM_BYTES) ? 25'(MEM_BYTES - 1) : ebyte_raw;
	assign total     = TW'(frac_q) + TW'(phase_step);

	adpcmb_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
		.clk  (clk),
		.we   (st_q == S_IDLE && q_valid && !ovalid_q && q_data.op == OP_LOAD &&
		       32'(q_data.mem_address) < MEM_BYTES),
		.waddr(AW'(q_data.mem_address)),
		.wdata(q_data.mem_byte),
		.raddr(AW'(nib_q >> 1)),
		.rdata(rdata)
	);

	// delta = fore*step/8 truncating toward zero
	logic signed [20:0] prod;
	logic [3:0] odd;
	assign odd  = {nib_val_q[2:0], 1'b1};
	assign prod = 21'(step_q) * 21'(odd);
	assign acc_sum = 18'(acc_q) + 18'(dlt_q);
	assign grow_div = 17'(grow_q >> 6);
	assign s_mag = s_q < 0 ? -s_q : s_q;
	assign q_int = s_q < 0 ? -17'((s_mag + ((1 << FRAC_BITS) - 1)) >> FRAC_BITS)
	                       : 17'(s_q >>> FRAC_BITS);

	assign q_ready   = (st_q == S_IDLE) && !ovalid_q;
	assign busy      = (st_q != S_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (q_valid && !ovalid_q) it_q <= q_data;
			S_MUL: begin
				dlt_q  <= nib_val_q[3] ? -((prod) >>> 3) : (prod >>> 3);
				grow_q <= 23'(step_q) * 23'(grow_factor(nib_val_q[2:0]));
			end
			S_INT: s_q <= (FRAC_BITS+18)'(prev_q) * (FRAC_BITS+18)'((1 << FRAC_BITS) - frac_q)
			            + (FRAC_BITS+18)'(acc_q) * (FRAC_BITS+18)'($signed({1'b0, frac_q}));
			S_VOL: smp_q <= 32'(q_int) * $signed({16'd0, volume_gain});
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; nib_q <= '0; frac_q <= '0; acc_q <= '0; prev_q <= '0;
			step_q <= STEP_MIN; byte_q <= '0; play_q <= 1'b0; rpt_q <= 1'b0;
			ext_q <= 1'b0; eos_q <= 1'b0; whole_q <= '0; nib_val_q <= '0;
			ovalid_q <= 1'b0; odata_q <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (st_q)
				S_IDLE: if (q_valid && !ovalid_q) begin
					case (q_data.op)
						OP_LOAD, OP_STOP: begin
							if (q_data.op == OP_STOP) begin
								play_q <= 1'b0; rpt_q <= 1'b0; ext_q <= 1'b0;
							end
							st_q <= S_OUT;
						end
						OP_START: begin
							play_q <= sbyte < 25'(MEM_BYTES);
							rpt_q  <= q_data.repeat_flag && sbyte < 25'(MEM_BYTES);
							ext_q  <= q_data.external_mode && sbyte < 25'(MEM_BYTES);
							eos_q  <= 1'b0;
							nib_q  <= sbyte << 1;
							frac_q <= '0; acc_q <= '0; prev_q <= '0; step_q <= STEP_MIN;
							st_q <= S_OUT;
						end
						default: begin
							if (ext_q) begin
								frac_q  <= total[FRAC_BITS-1:0];
								whole_q <= WH'(total >> FRAC_BITS);
								st_q <= S_CHECK;
							end else begin
								st_q <= S_OUT;
							end
						end
					endcase
				end
				S_CHECK: begin
					if (whole_q == '0) begin
						st_q <= S_INT;
					end else if (nib_q == (ebyte << 1)) begin
						if (rpt_q) begin
							nib_q <= sbyte << 1; acc_q <= '0; prev_q <= '0;
							step_q <= STEP_MIN;
							st_q <= S_RDWT;
						end else begin
							play_q <= 1'b0; rpt_q <= 1'b0; ext_q <= 1'b0; eos_q <= 1'b1;
							prev_q <= '0; st_q <= S_OUT;
						end
					end else begin
						st_q <= nib_q[0] ? S_RD : S_RDWT;
					end
				end
				S_RDWT: st_q <= S_RD;
				S_RD: begin
					if (nib_q[0]) begin
						nib_val_q <= byte_q[3:0];
					end else begin
						byte_q    <= (nib_q >> 1) < 25'(MEM_BYTES) ? rdata : 8'd0;
						nib_val_q <= (nib_q >> 1) < 25'(MEM_BYTES) ? rdata[7:4] : 4'd0;
					end
					nib_q <= nib_q + NIB_W'(1);
					whole_q <= whole_q - WH'(1);
					st_q <= S_MUL;
				end
				S_MUL: st_q <= S_UPD;
				S_UPD: begin
					prev_q <= acc_q;
					acc_q  <= acc_sum > 18'sd32767 ? 16'sh7fff :
					          acc_sum < -18'sd32768 ? 16'sh8000 : 16'(acc_sum);
					step_q <= grow_div > 17'(STEP_MAX) ? STEP_MAX :
					          grow_div < 17'(STEP_MIN) ? STEP_MIN : 15'(grow_div);
					st_q <= S_CHECK;
				end
				S_INT: st_q <= S_VOL;
				S_VOL: begin
					st_q <= S_OUT;
				end
				S_OUT: begin
					ovalid_q <= 1'b1;
					odata_q.sample <= (it_q.op == OP_TICK && ext_q) ? smp_q : 32'sd0;
					odata_q.end_of_sample <= eos_q;
					odata_q.playing <= play_q && ext_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/sv/adpcm_b_sample_player_tb.sv =====
`timescale 1ns / 1ps

module adpcm_b_sample_player_tb;
	import adpcmb_pkg::*;

	localparam int N_ITEMS = 1950;
	localparam int IDLE_LIMIT = 4000;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int unsigned NIB_MASK = (1 << NIB_W) - 1;

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      in_valid = 0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 0;
	out_item_t out_data;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [17:0] cfg_data = '0;

	adpcm_b_sample_player DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// player model state
	logic [7:0]  rom_bytes [MEM_BYTES_DEF];
	int unsigned nib_addr, phase_frac;
	int          acc, last_acc, step_sz;
	logic [7:0]  cur_byte;
	bit          pl_run, pl_loop, pl_ext, eos;
	int unsigned r_start, r_end, r_shift, r_pstep, r_vol;

	out_item_t pending_samples [$];
	int n_items, n_results, n_phases, n_errors;
	int burst_left, stall_left, stall_mode;
	int idle_cycles;

	function automatic int unsigned eff_shift();
		return (r_shift > 8) ? 8 : r_shift;
	endfunction

	function automatic int unsigned start_addr();
		return r_start << eff_shift();
	endfunction

	function automatic int unsigned end_addr();
		int unsigned e;
		e = (r_end << eff_shift()) + ((1 << eff_shift()) - 1);
		return (e >= MEM_BYTES_DEF) ? MEM_BYTES_DEF - 1 : e;
	endfunction

	function automatic void reset_predictor();
		acc = 0;
		last_acc = 0;
		step_sz = 127;
	endfunction

	function automatic void decode_nibble(logic [3:0] n);
		int mag, grow;
		mag = 2 * n[2:0] + 1;
		case (n[2:0])
			3'd4:    grow = 77;
			3'd5:    grow = 102;
			3'd6:    grow = 128;
			3'd7:    grow = 153;
			default: grow = 57;
		endcase
		last_acc = acc;
		acc += ((n[3] ? -mag : mag) * step_sz) / 8;
		if (acc > 32767) acc = 32767;
		else if (acc < -32768) acc = -32768;
		step_sz = (step_sz * grow) / 64;
		if (step_sz > 24576) step_sz = 24576;
		else if (step_sz < 127) step_sz = 127;
	endfunction

	function automatic bit advance_phase();
		int unsigned total, whole;
		logic [3:0] n;
		total = phase_frac + r_pstep;
		whole = total >> FRAC;
		phase_frac = total & ((1 << FRAC) - 1);
		while (whole > 0) begin
			whole--;
			if (nib_addr == ((end_addr() << 1) & NIB_MASK)) begin
				if (pl_loop) begin
					nib_addr = (start_addr() << 1) & NIB_MASK;
					reset_predictor();
				end else begin
					pl_run = 0;
					pl_loop = 0;
					pl_ext = 0;
					eos = 1;
					last_acc = 0;
					return 0;
				end
			end
			if (nib_addr & 1) begin
				n = cur_byte[3:0];
			end else begin
				cur_byte = ((nib_addr >> 1) < MEM_BYTES_DEF) ? rom_bytes[nib_addr >> 1] : 8'd0;
				n = cur_byte[7:4];
			end
			nib_addr = (nib_addr + 1) & NIB_MASK;
			decode_nibble(n);
		end
		return 1;
	endfunction

	function automatic int interp_volume();
		longint one, ph, s, q;
		one = longint'(1) << FRAC;
		ph = phase_frac;
		s = longint'(last_acc) * (one - ph) + longint'(acc) * ph;
		if (s >= 0) q = s >>> FRAC;
		else q = -((-s + one - 1) >>> FRAC);
		return int'(q * longint'(r_vol));
	endfunction

	function automatic out_item_t play_item(in_item_t it);
		out_item_t o;
		o.sample = 0;
		case (it.op)
			OP_LOAD: rom_bytes[it.mem_address] = it.mem_byte;
			OP_START: begin
				pl_run = 1;
				pl_loop = it.repeat_flag;
				pl_ext = it.external_mode;
				eos = 0;
				nib_addr = (start_addr() << 1) & NIB_MASK;
				phase_frac = 0;
				reset_predictor();
				if (start_addr() >= MEM_BYTES_DEF) begin
					pl_run = 0;
					pl_loop = 0;
					pl_ext = 0;
				end
			end
			OP_STOP: begin
				pl_run = 0;
				pl_loop = 0;
				pl_ext = 0;
			end
			default: begin
				if (pl_ext && advance_phase()) o.sample = interp_volume();
			end
		endcase
		o.end_of_sample = eos;
		o.playing = pl_run && pl_ext;
		return o;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", field, got, want, n_results);
		n_errors++;
	endtask

	task automatic send(in_item_t it, bit typed = 0, out_item_t want = '0);
		out_item_t o;
		int gap;
		@(negedge clk);
		in_valid = 1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
		o = play_item(it);
		pending_samples.push_back(typed ? want : o);
		n_items++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 0;
				repeat (gap - 1) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val[17:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_START: r_start = val & 16'hFFFF;
			REG_END:   r_end = val & 16'hFFFF;
			REG_SHIFT: r_shift = val & 4'hF;
			REG_PSTEP: r_pstep = val & 18'h3FFFF;
			REG_VOL:   r_vol = val & 16'hFFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic in_item_t mk(logic [1:0] op, int unsigned a = 0, int unsigned b = 0,
			bit rep = 0, bit ext = 0);
		in_item_t it;
		it.op = op;
		it.mem_address = a[15:0];
		it.mem_byte = b[7:0];
		it.repeat_flag = rep;
		it.external_mode = ext;
		return it;
	endfunction

	function automatic in_item_t rnd_tick();
		in_item_t it;
		it = in_item_t'(28'($urandom));
		it.op = OP_TICK;
		return it;
	endfunction

	// receiver stalls in runs: always ready, coin flip, or held off
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(1, 40);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_ready <= 1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= 0;
		endcase
	end

	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			n_results++;
			if (pending_samples.size() == 0) begin
				$display("MISMATCH unexpected transaction (result %0d)", n_results);
				n_errors++;
			end else begin
				want = pending_samples.pop_front();
				if (out_data.sample !== want.sample)
					report("sample", out_data.sample, want.sample);
				if (out_data.end_of_sample !== want.end_of_sample)
					report("end_of_sample", out_data.end_of_sample, want.end_of_sample);
				if (out_data.playing !== want.playing)
					report("playing", out_data.playing, want.playing);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		dir_row_t rows [$];
		dir_row_t row;
		int unsigned esh, span, sp, ep, sb, eb, k, r;
		reset_predictor();
		nib_addr = 0; phase_frac = 0; cur_byte = 0;
		pl_run = 0; pl_loop = 0; pl_ext = 0; eos = 0;
		r_start = 0; r_end = 0; r_shift = 0; r_pstep = 0; r_vol = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_reg(REG_START, 0);
		write_reg(REG_END, 3);
		write_reg(REG_SHIFT, 0);
		write_reg(REG_PSTEP, 262143);
		write_reg(REG_VOL, 65535);

		row.typed = 1; row.want = '0;
		row.it = mk(OP_TICK, 65535, 255, 1, 1);       rows.push_back(row);
		row.it = mk(OP_LOAD, 65535, 255);             rows.push_back(row);
		row.it = mk(OP_LOAD, 0, 0);                   rows.push_back(row);
		row.it = mk(OP_LOAD, 1, 255);                 rows.push_back(row);
		row.it = mk(OP_LOAD, 2, 127);                 rows.push_back(row);
		row.it = mk(OP_LOAD, 3, 128);                 rows.push_back(row);
		row.it = mk(OP_START, 0, 0, 1, 0);            rows.push_back(row);
		row.it = mk(OP_TICK);                         rows.push_back(row);
		row.it = mk(OP_STOP);                         rows.push_back(row);
		row.typed = 0;
		row.it = mk(OP_START, 0, 0, 1, 1);            rows.push_back(row);
		repeat (5) begin row.it = mk(OP_TICK); rows.push_back(row); end
		row.it = mk(OP_STOP);                         rows.push_back(row);
		row.it = mk(OP_TICK);                         rows.push_back(row);
		row.it = mk(OP_START, 0, 0, 0, 1);            rows.push_back(row);
		repeat (4) begin row.it = mk(OP_TICK); rows.push_back(row); end
		row.it = mk(OP_START, 0, 0, 0, 1);            rows.push_back(row);
		foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].want);
		drain();

		while (n_items < N_ITEMS) begin
			n_phases++;
			esh = $urandom_range(0, 15);
			write_reg(REG_SHIFT, esh);
			if (esh > 8) esh = 8;
			r = $urandom_range(0, 99);
			if (r < 8 && esh > 0) begin
				// start beyond the store
				sp = $urandom_range(65536 >> esh, 65535);
				ep = $urandom_range(0, 65535);
			end else if (r < 16) begin
				// end beyond the store, clamped
				sp = (65536 >> esh) - 1;
				ep = $urandom_range(sp, 65535);
			end else begin
				span = (esh >= 5) ? 0 : $urandom_range(0, 31 >> esh);
				sp = $urandom_range(0, (65536 >> esh) - 1 - span);
				ep = sp + span;
			end
			write_reg(REG_START, sp);
			write_reg(REG_END, ep);
			r = $urandom_range(0, 9);
			write_reg(REG_PSTEP, r == 0 ? 0 : r == 1 ? 262143 :
				r < 5 ? $urandom_range(1, 65535) : $urandom_range(0, 262143));
			r = $urandom_range(0, 9);
			write_reg(REG_VOL, r == 0 ? 0 : r == 1 ? 65535 : $urandom_range(0, 65535));

			sb = start_addr();
			eb = end_addr();
			if (sb < MEM_BYTES_DEF)
				for (k = sb; k <= eb; k++) send(mk(OP_LOAD, k, $urandom_range(0, 255)));
			send(mk(OP_START, $urandom, $urandom, 1'($urandom_range(0, 1)),
				$urandom_range(0, 6) != 0));
			repeat ($urandom_range(8, 40)) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					send(mk(OP_STOP, $urandom, $urandom, 1'($urandom), 1'($urandom)));
				else if (r < 8)
					send(mk(OP_START, $urandom, $urandom, 1'($urandom_range(0, 1)),
						$urandom_range(0, 6) != 0));
				else if (r < 12)
					send(mk(OP_LOAD, $urandom_range(0, 65535), $urandom_range(0, 255)));
				else
					send(rnd_tick());
			end
			drain();
		end

		$display("Ran %0d transactions in %0d configuration phases, %0d results checked",
			n_items, n_phases, n_results);
		$display("Covered loads, starts in and past range, stops, looping and end-of-sample");
		if (n_errors == 0 && pending_samples.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
